// File: src/wola_pkg.sv
// shared widths, codes and result word type of the weighted overlap-add core
package wola_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 9;
  localparam int ACC_W      = 32;
  localparam int OUT_W      = 16;
  localparam int CFG_W      = 10;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int PROD_SHIFT = 21;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 10'd480;
  localparam logic [CFG_W-1:0] HOP_LENGTH_RESET    = 10'd160;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_HOP_LENGTH    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OUT_W-1:0] sample;
    logic             hop_last;
  } out_word_t;

endpackage

// File: src/windowed_overlap_add_core.sv
// top level of the weighted overlap-add synthesis core
//
// Weighted overlap-add for inverse STFT synthesis. Input words are either
// window coefficient writes (op high: signed Q15 coefficient into table entry
// coef_index) or frame samples (op low: one signed Q21 inverse transform
// output). The core counts the frame position itself; each sample is scaled
// by its window coefficient, shifted right 21 with floor rounding and added
// with 32-bit saturation into a ring accumulator slot. The first hop_length
// positions of a frame each return one word: the slot sum saturated to 16
// bits, with hop_last set on the last word of the hop; that slot is then
// cleared. Every window entry must be written before a sample reads it.
// Throughput is one word per cycle on both sides when nothing stalls; a frame
// sample that returns a result passes the front queue, the window table read
// and the registered product with the accumulator read, after which the
// saturated sum goes straight into the result queue. A full result queue
// stalls the back end when a result is due. The window table and the
// accumulator are each one MAX_WINDOW-deep ram. After reset the core zeroes
// every accumulator slot with full high; configuration writes are taken
// during that time. Configuration takes effect at once and should be changed
// only while the core is idle.
module windowed_overlap_add_core #(
  parameter int MAX_WINDOW = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input queue side
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic                                 op_i,
  input  logic signed [wola_pkg::SAMPLE_W-1:0] frame_sample_i,
  input  logic [wola_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [wola_pkg::COEF_W-1:0]   coef_value_i,
  // result queue side
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic signed [wola_pkg::OUT_W-1:0]    out_sample_o,
  output logic                                 hop_last_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_index_i,
  input  logic [wola_pkg::CFG_W-1:0]           cfg_data_i
);
  import wola_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int QW = 3 + SAMPLE_W + COEF_W + 2 * AW;
  localparam int ITEM_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH  = 2;

  // configuration registers
  logic [CFG_W-1:0] window_length_q, window_length_d;
  logic [CFG_W-1:0] hop_length_q, hop_length_d;

  // front to back queue
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wr_item, q_rd_item;

  // back to result queue
  logic      out_push, out_full, clearing;
  out_word_t out_wr_word, out_rd_word;

  always_comb begin
    window_length_d = window_length_q;
    hop_length_d    = hop_length_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WINDOW_LENGTH: window_length_d = cfg_data_i;
        CFG_HOP_LENGTH:    hop_length_d    = cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_LENGTH_RESET;
      hop_length_q    <= HOP_LENGTH_RESET;
    end else begin
      window_length_q <= window_length_d;
      hop_length_q    <= hop_length_d;
    end
  end

  // front: frame position, ring slot, emit and hop_last decisions
  wola_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .op_i            (op_i),
    .frame_sample_i  (frame_sample_i),
    .coef_index_i    (coef_index_i),
    .coef_value_i    (coef_value_i),
    .window_length_i (window_length_q),
    .hop_length_i    (hop_length_q),
    .q_full_i        (q_full),
    .clearing_i      (clearing),
    .q_push_o        (q_push),
    .q_item_o        (q_wr_item)
  );

  // decoupling queue, keeps word order between table writes and reads
  wola_fifo #(
    .WIDTH (QW),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_item),
    .empty_o (q_empty)
  );

  // back: window lookup, multiply, accumulate, saturate
  wola_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_rd_item),
    .q_pop_o    (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_word_o (out_wr_word),
    .clearing_o (clearing)
  );

  // result queue doubles as the output register and skid stage
  wola_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wr_word),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_rd_word),
    .empty_o (empty_o)
  );

  assign out_sample_o = out_rd_word.sample;
  assign hop_last_o   = out_rd_word.hop_last;

endmodule

// File: src/wola_ram.sv
// generic single-write, single-read ram with registered read data
module wola_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wola_fifo.sv
// small flop-based first-in first-out queue
module wola_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/wola_front.sv
// front end: accepts words, tracks frame position and ring base, classifies
module wola_front #(
  parameter int MAX_WINDOW = 512,
  localparam int AW = $clog2(MAX_WINDOW),
  localparam int QW = 3 + wola_pkg::SAMPLE_W + wola_pkg::COEF_W + 2 * AW
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic                                  op_i,
  input  logic signed [wola_pkg::SAMPLE_W-1:0]  frame_sample_i,
  input  logic [wola_pkg::COEF_IDX_W-1:0]       coef_index_i,
  input  logic signed [wola_pkg::COEF_W-1:0]    coef_value_i,
  input  logic [wola_pkg::CFG_W-1:0]            window_length_i,
  input  logic [wola_pkg::CFG_W-1:0]            hop_length_i,
  input  logic                                  q_full_i,
  input  logic                                  clearing_i,
  output logic                                  q_push_o,
  output logic [QW-1:0]                         q_item_o
);
  import wola_pkg::*;

  localparam int LW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int SW = AW + 1;
  localparam int IW = (AW + 1 > COEF_IDX_W) ? AW + 1 : COEF_IDX_W;
  localparam logic [LW-1:0] MAX_LW = LW'(MAX_WINDOW);
  localparam logic [SW-1:0] MAX_SW = SW'(MAX_WINDOW);
  localparam logic [IW-1:0] MAX_IW = IW'(MAX_WINDOW);

  typedef struct packed {
    logic                is_coef;
    logic                emit;
    logic                last;
    logic [SAMPLE_W-1:0] sample;
    logic [COEF_W-1:0]   coef;
    logic [AW-1:0]       pos;
    logic [AW-1:0]       slot;
  } q_item_t;

  logic [AW-1:0] frame_pos_q, frame_pos_d;
  logic [AW-1:0] ring_base_q, ring_base_d;
  logic [LW-1:0] wl_raw, hp_raw, wl_eff, hp_eff, pos_ext;
  logic [SW-1:0] slot_sum, base_sum;
  logic [IW-1:0] idx_ext;
  logic          accept, is_coef, idx_ok, emit, last, frame_end;
  q_item_t       item;

  assign full_o  = q_full_i | clearing_i;
  assign accept  = push_i & ~full_o;
  assign is_coef = (op_i == OP_COEF);
  assign idx_ext = IW'(coef_index_i);
  assign idx_ok  = (idx_ext < MAX_IW);

  // effective window and hop after range clamping
  always_comb begin
    wl_raw = LW'(window_length_i);
    hp_raw = LW'(hop_length_i);
    if (wl_raw == '0) begin
      wl_eff = LW'(1);
    end else if (wl_raw > MAX_LW) begin
      wl_eff = MAX_LW;
    end else begin
      wl_eff = wl_raw;
    end
    if (hp_raw == '0) begin
      hp_eff = LW'(1);
    end else if (hp_raw > wl_eff) begin
      hp_eff = wl_eff;
    end else begin
      hp_eff = hp_raw;
    end
  end

  assign pos_ext   = LW'(frame_pos_q);
  assign emit      = (pos_ext < hp_eff);
  assign last      = (pos_ext == hp_eff - LW'(1));
  assign frame_end = (pos_ext + LW'(1) >= wl_eff);

  // ring slot and next base, both wrap once at most
  always_comb begin
    slot_sum = SW'(ring_base_q) + SW'(frame_pos_q);
    if (slot_sum >= MAX_SW) begin
      slot_sum = slot_sum - MAX_SW;
    end
    base_sum = SW'(ring_base_q) + hp_eff[SW-1:0];
    if (base_sum >= MAX_SW) begin
      base_sum = base_sum - MAX_SW;
    end
  end

  always_comb begin
    frame_pos_d = frame_pos_q;
    ring_base_d = ring_base_q;
    if (accept && !is_coef) begin
      if (frame_end) begin
        frame_pos_d = '0;
        ring_base_d = base_sum[AW-1:0];
      end else begin
        frame_pos_d = frame_pos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q <= '0;
      ring_base_q <= '0;
    end else begin
      frame_pos_q <= frame_pos_d;
      ring_base_q <= ring_base_d;
    end
  end

  always_comb begin
    item.is_coef = is_coef;
    item.emit    = emit;
    item.last    = last;
    item.sample  = frame_sample_i;
    item.coef    = coef_value_i;
    item.pos     = is_coef ? idx_ext[AW-1:0] : frame_pos_q;
    item.slot    = slot_sum[AW-1:0];
  end

  // out-of-table coefficient writes are dropped here
  assign q_push_o = accept & (~is_coef | idx_ok);
  assign q_item_o = item;

endmodule

// File: src/wola_back.sv
// back end: window lookup, multiply, overlap accumulate and saturation
module wola_back #(
  parameter int MAX_WINDOW = 512,
  localparam int AW = $clog2(MAX_WINDOW),
  localparam int QW = 3 + wola_pkg::SAMPLE_W + wola_pkg::COEF_W + 2 * AW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  logic [QW-1:0]       q_item_i,
  output logic                q_pop_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output wola_pkg::out_word_t out_word_o,
  output logic                clearing_o
);
  import wola_pkg::*;

  localparam int SH_W = PROD_W - PROD_SHIFT;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);
  localparam logic signed [ACC_W:0] SUM_OUT_MAX = (ACC_W + 1)'(OUT_MAX);
  localparam logic signed [ACC_W:0] SUM_OUT_MIN = (ACC_W + 1)'(OUT_MIN);

  typedef struct packed {
    logic                is_coef;
    logic                emit;
    logic                last;
    logic [SAMPLE_W-1:0] sample;
    logic [COEF_W-1:0]   coef;
    logic [AW-1:0]       pos;
    logic [AW-1:0]       slot;
  } q_item_t;

  q_item_t head;
  q_item_t b1_item_q, b2_item_q;
  logic    b1_valid_q, b1_valid_d, b2_valid_q, b2_valid_d;
  logic signed [PROD_W-1:0] prod, b2_prod_q;

  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic                win_we, win_re;
  logic [COEF_W-1:0]   win_rdata;
  logic                acc_we, acc_re;
  logic [AW-1:0]       acc_waddr;
  logic [ACC_W-1:0]    acc_wdata, acc_rdata;

  // last accumulator write, forwarded to a read that overtook it
  logic                fwd_valid_q;
  logic [AW-1:0]       fwd_slot_q;
  logic [ACC_W-1:0]    fwd_data_q;

  logic signed [ACC_W-1:0] acc_old, acc_sat;
  logic signed [SH_W-1:0]  shifted;
  logic signed [ACC_W:0]   sum;
  logic [OUT_W-1:0]        out_sat;
  logic                    head_valid, adv;

  assign head       = q_item_i;
  assign head_valid = ~q_empty_i;
  assign adv        = ~clr_active_q & ~(b2_valid_q & b2_item_q.emit & out_full_i);
  assign q_pop_o    = adv & head_valid;
  assign clearing_o = clr_active_q;

  // stage 0: coefficient writes complete here, samples look up the window
  assign win_we = adv & head_valid & head.is_coef;
  assign win_re = adv & head_valid & ~head.is_coef;

  wola_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (head.pos),
    .wdata_i (head.coef),
    .re_i    (win_re),
    .raddr_i (head.pos),
    .rdata_o (win_rdata)
  );

  // stage 1: product, accumulator read
  assign prod   = $signed(win_rdata) * $signed(b1_item_q.sample);
  assign acc_re = adv & b1_valid_q;

  // stage 2: floor shift, saturating add, slot write-back
  assign acc_old = (fwd_valid_q && fwd_slot_q == b2_item_q.slot) ? fwd_data_q : acc_rdata;
  assign shifted = b2_prod_q[PROD_W-1:PROD_SHIFT];
  assign sum     = (ACC_W + 1)'(acc_old) + (ACC_W + 1)'(shifted);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
    if (sum > SUM_OUT_MAX) begin
      out_sat = OUT_MAX;
    end else if (sum < SUM_OUT_MIN) begin
      out_sat = OUT_MIN;
    end else begin
      out_sat = sum[OUT_W-1:0];
    end
  end

  always_comb begin
    if (clr_active_q) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr_q;
      acc_wdata = '0;
    end else begin
      acc_we    = adv & b2_valid_q;
      acc_waddr = b2_item_q.slot;
      acc_wdata = b2_item_q.emit ? '0 : acc_sat;
    end
  end

  wola_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WINDOW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (b1_item_q.slot),
    .rdata_o (acc_rdata)
  );

  assign out_push_o          = adv & b2_valid_q & b2_item_q.emit;
  assign out_word_o.sample   = out_sat;
  assign out_word_o.hop_last = b2_item_q.last;

  always_comb begin
    b1_valid_d = b1_valid_q;
    b2_valid_d = b2_valid_q;
    if (adv) begin
      b1_valid_d = head_valid & ~head.is_coef;
      b2_valid_d = b1_valid_q;
    end
    clr_addr_d   = clr_addr_q;
    clr_active_d = clr_active_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q   <= 1'b0;
      b2_valid_q   <= 1'b0;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      fwd_valid_q  <= 1'b0;
    end else begin
      b1_valid_q   <= b1_valid_d;
      b2_valid_q   <= b2_valid_d;
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      if (acc_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_item_q <= head;
      b2_item_q <= b1_item_q;
      b2_prod_q <= prod;
    end
    if (acc_we) begin
      fwd_slot_q <= acc_waddr;
      fwd_data_q <= acc_wdata;
    end
  end

endmodule

// File: src/wola_checker.sv
// port-level checks for the overlap-add core, bound to the top level
module wola_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              push_i,
  input logic                              full_o,
  input logic                              op_i,
  input logic                              empty_o,
  input logic                              pop_i,
  input logic [wola_pkg::OUT_W-1:0]        out_sample_o,
  input logic                              hop_last_o
);
  import wola_pkg::*;

  logic seen_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_sample_q <= 1'b0;
    end else if (push_i && !full_o && op_i == OP_SAMPLE) begin
      seen_sample_q <= 1'b1;
    end
  end

  // waiting word holds until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_sample_o) && $stable(hop_last_o))
    else $error("result word changed while waiting");

  // accumulator clearing pass blocks input and nothing is pending
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> full_o && empty_o)
    else $error("core not in clearing pass after reset");

  // coefficient writes alone never produce a word
  a_word_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty_o) |-> seen_sample_q)
    else $error("result word without any frame sample");

endmodule

bind windowed_overlap_add_core wola_checker u_wola_checker (.*);
